// ----- rtl/gcl_pkg.sv -----
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types and constants for the gcd / lcm unit: operand range limits,
// divider sizing, and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package gcl_pkg;

   // port widths of the operands and the lcm
   localparam int DATA_WIDTH    = 32;
   localparam int WIDE_WIDTH    = 2 * DATA_WIDTH;

   // operand range limits
   localparam int OPERAND_WIDTH = 32;
   localparam logic [DATA_WIDTH-1:0] OPERAND_MAX =
      DATA_WIDTH'((64'd1 << OPERAND_WIDTH) - 64'd1);
   localparam logic [DATA_WIDTH-1:0] MIN_OPERAND = DATA_WIDTH'(2);

   // restoring divider, one quotient bit per cycle
   localparam int DIV_STEPS      = DATA_WIDTH;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST_COUNT = DIV_CNT_WIDTH'(DIV_STEPS - 1);

   // controller to datapath commands
   typedef struct packed {
      logic load;           // capture operands into x, y, a, b
      logic start_mod;      // start divider: x / y
      logic start_lcm;      // start divider: a / x
      logic div_step;       // one divider iteration
      logic euclid_update;  // x <= y, y <= remainder
      logic publish_ok;     // load gcd and lcm into the output register
      logic publish_err;    // load range error result into the output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic range_bad;      // an operand is out of range
      logic y_zero;         // euclid loop finished
      logic div_last;       // divider is on its final iteration
   } status_type;

endpackage

// ----- rtl/gcd_lcm_unit.sv -----
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor by euclid's remainder method and least common
// multiple as (a / gcd) * b with a full 64-bit result. One request at a
// time: every euclid remainder and the final a / gcd go through one
// shared restoring divider at one quotient bit per cycle, followed by a
// combinational multiply into the output register. An operand below 2
// gives a range error with zero results. The next request is taken while
// a finished result waits in the output register.
// ----------------------------------------------------------------------------
module gcd_lcm_unit
   import gcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_operand_a,
   input  logic [DATA_WIDTH-1:0] req_operand_b,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_divisor_out,
   output logic [WIDE_WIDTH-1:0] rsp_multiple_out,
   output logic                  rsp_range_error
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   gcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   gcl_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .operand_a    (req_operand_a),
      .operand_b    (req_operand_b),
      .divisor_out  (rsp_divisor_out),
      .multiple_out (rsp_multiple_out),
      .range_error  (rsp_range_error)
   );

endmodule

// ----- rtl/gcl_datapath.sv -----
// ----------------------------------------------------------------------------
// gcl_datapath
// Operand registers, euclid registers, shared restoring divider, the lcm
// multiplier and the result register.
// ----------------------------------------------------------------------------
module gcl_datapath
   import gcl_pkg::*;
(
   input  logic                  clock,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [DATA_WIDTH-1:0] operand_a,
   input  logic [DATA_WIDTH-1:0] operand_b,
   output logic [DATA_WIDTH-1:0] divisor_out,
   output logic [WIDE_WIDTH-1:0] multiple_out,
   output logic                  range_error
);

   logic [DATA_WIDTH-1:0]    a_ff, b_ff, x_ff, y_ff;
   logic [DATA_WIDTH-1:0]    rem_ff, quo_ff, dsr_ff;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff;
   logic [DATA_WIDTH-1:0]    rem_in, quo_in;
   logic [DATA_WIDTH:0]      shifted;
   logic [DATA_WIDTH:0]      diff;
   logic [WIDE_WIDTH-1:0]    product;
   logic [DATA_WIDTH-1:0]    divisor_ff;
   logic [WIDE_WIDTH-1:0]    multiple_ff;
   logic                     error_ff;

   // operand range check on the captured operands
   assign status.range_bad = (a_ff < MIN_OPERAND) || (b_ff < MIN_OPERAND) ||
                             (a_ff > OPERAND_MAX) || (b_ff > OPERAND_MAX);
   assign status.y_zero    = (y_ff == '0);
   assign status.div_last  = (cnt_ff == DIV_LAST_COUNT);

   // one restoring divide iteration
   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (!diff[DATA_WIDTH]) begin
         rem_in = diff[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = shifted[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
      end
   end

   // (a / gcd) * b
   assign product = quo_ff * b_ff;

   // operand and euclid registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= operand_a;
         b_ff <= operand_b;
         x_ff <= operand_a;
         y_ff <= operand_b;
      end else if (cmd.euclid_update) begin
         x_ff <= y_ff;
         y_ff <= rem_ff;
      end
   end

   // shared divider
   always_ff @(posedge clock) begin
      if (cmd.start_mod) begin
         quo_ff <= x_ff;
         dsr_ff <= y_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.start_lcm) begin
         quo_ff <= a_ff;
         dsr_ff <= x_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.publish_ok) begin
         divisor_ff  <= x_ff;
         multiple_ff <= product;
         error_ff    <= 1'b0;
      end else if (cmd.publish_err) begin
         divisor_ff  <= '0;
         multiple_ff <= '0;
         error_ff    <= 1'b1;
      end
   end

   assign divisor_out  = divisor_ff;
   assign multiple_out = multiple_ff;
   assign range_error  = error_ff;

endmodule

// ----- rtl/gcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// gcl_ctrl
// Sequencer for the gcd / lcm unit: runs the euclid remainder loop and the
// lcm divide on the shared divider, and owns both handshakes.
// ----------------------------------------------------------------------------
module gcl_ctrl
   import gcl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CHECK   = 6'b000010,
      ST_DIV_MOD = 6'b000100,
      ST_EUCLID  = 6'b001000,
      ST_DIV_LCM = 6'b010000,
      ST_MULT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a new result
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.range_bad) begin
               if (out_free) begin
                  cmd.publish_err = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else if (status.y_zero) begin
               cmd.start_lcm = 1'b1;
               state_in      = ST_DIV_LCM;
            end else begin
               cmd.start_mod = 1'b1;
               state_in      = ST_DIV_MOD;
            end
         end
         ST_DIV_MOD: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_EUCLID;
         end
         ST_EUCLID: begin
            cmd.euclid_update = 1'b1;
            state_in          = ST_CHECK;
         end
         ST_DIV_LCM: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_MULT;
         end
         ST_MULT: begin
            if (out_free) begin
               cmd.publish_ok = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.publish_ok || cmd.publish_err) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/gcl_assert.sv -----
// ----------------------------------------------------------------------------
// gcl_assert
// Port-level checks for the gcd / lcm unit, bound to the top level.
// ----------------------------------------------------------------------------
module gcl_assert
   import gcl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DATA_WIDTH-1:0] rsp_divisor_out,
   input logic [WIDE_WIDTH-1:0] rsp_multiple_out,
   input logic                  rsp_range_error
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a range error carries zero results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_divisor_out == '0 && rsp_multiple_out == '0)
      else $error("range error with nonzero results");

   // a good result has a nonzero gcd and lcm
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_error |-> rsp_divisor_out != '0 && rsp_multiple_out != '0)
      else $error("zero gcd or lcm without range error");

   // the unit is busy in the cycle after it takes a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

endmodule

bind gcd_lcm_unit gcl_assert u_gcl_assert (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_divisor_out  (rsp_divisor_out),
   .rsp_multiple_out (rsp_multiple_out),
   .rsp_range_error  (rsp_range_error)
);
